// File: sv/mcms_pkg.sv
`timescale 1ns / 1ps

package mcms_pkg;

    localparam int NUM_RUN_REGS = 4;
    localparam logic [17:0] COUNT_MAX = 18'h3FFFF;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [2:0] CMD_NONE        = 3'd0;
    localparam logic [2:0] CMD_OPEN_START  = 3'd1;
    localparam logic [2:0] CMD_OPEN_STOP   = 3'd2;
    localparam logic [2:0] CMD_CLOSE_START = 3'd3;
    localparam logic [2:0] CMD_CLOSE_STOP  = 3'd4;

    localparam logic [2:0] REG_ENABLE_MASK = 3'd0;
    localparam logic [2:0] REG_RUN_CH0     = 3'd1;
    localparam logic [2:0] REG_RUN_CH1     = 3'd2;
    localparam logic [2:0] REG_RUN_CH2     = 3'd3;
    localparam logic [2:0] REG_RUN_CH3     = 3'd4;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] channel;
        logic       switch_setting;
        logic [7:0] percent;
    } t_in_item;

    typedef struct packed {
        logic [2:0] motor_command;
        logic [1:0] command_channel;
        logic [7:0] command_percent;
        logic       read_switch;
        logic [7:0] read_percent;
        logic       error;
    } t_out_item;

    typedef struct packed {
        logic [NUM_RUN_REGS-1:0]             enable_mask;
        logic [NUM_RUN_REGS-1:0][17:0]       run_limit;
    } t_cfg;

endpackage

// File: sv/mcms_cfg.sv
`timescale 1ns / 1ps

module mcms_cfg #(
    parameter int TICKS_PER_SECOND = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output mcms_pkg::t_cfg        o_cfg
);

    localparam int RESET_TICKS = 2 * TICKS_PER_SECOND;
    localparam logic [17:0] RESET_LIMIT =
        (RESET_TICKS > 32'h3FFFF) ? 18'h3FFFF : 18'(RESET_TICKS);

    logic [3:0]  r_enable_mask;
    logic [13:0] r_run_seconds [mcms_pkg::NUM_RUN_REGS];
    logic [17:0] r_run_limit   [mcms_pkg::NUM_RUN_REGS];

    logic        wr_en;
    logic [2:0]  reg_idx;
    logic [1:0]  run_idx;
    logic [13:0] wr_seconds;
    logic [13:0] clamped_seconds;
    logic [31:0] product;
    logic [17:0] n_limit;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];
    assign run_idx = 2'(reg_idx - 3'd1);

    assign wr_seconds      = pwdata[13:0];
    assign clamped_seconds = (wr_seconds < 14'd2) ? 14'd2 : wr_seconds;
    assign product         = 32'(clamped_seconds) * 32'(TICKS_PER_SECOND);
    assign n_limit         = (product > 32'(mcms_pkg::COUNT_MAX)) ?
                             mcms_pkg::COUNT_MAX : product[17:0];

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            mcms_pkg::REG_ENABLE_MASK: prdata = 32'(r_enable_mask);
            mcms_pkg::REG_RUN_CH0,
            mcms_pkg::REG_RUN_CH1,
            mcms_pkg::REG_RUN_CH2,
            mcms_pkg::REG_RUN_CH3:     prdata = 32'(r_run_seconds[run_idx]);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_mask <= '0;
            for (int i = 0; i < mcms_pkg::NUM_RUN_REGS; i++) begin
                r_run_seconds[i] <= 14'd2;
                r_run_limit[i]   <= RESET_LIMIT;
            end
        end else if (wr_en) begin
            unique case (reg_idx)
                mcms_pkg::REG_ENABLE_MASK: r_enable_mask <= pwdata[3:0];
                mcms_pkg::REG_RUN_CH0,
                mcms_pkg::REG_RUN_CH1,
                mcms_pkg::REG_RUN_CH2,
                mcms_pkg::REG_RUN_CH3: begin
                    r_run_seconds[run_idx] <= wr_seconds;
                    r_run_limit[run_idx]   <= n_limit;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.enable_mask = r_enable_mask;
        for (int i = 0; i < mcms_pkg::NUM_RUN_REGS; i++) begin
            o_cfg.run_limit[i] = r_run_limit[i];
        end
    end

endmodule

// File: sv/mcms_core.sv
`timescale 1ns / 1ps

module mcms_core #(
    parameter int CHANNELS   = 4,
    parameter int DEAD_TICKS = 200
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  mcms_pkg::t_in_item    i_item,
    input  mcms_pkg::t_cfg        i_cfg,
    output mcms_pkg::t_out_item   o_result
);

    localparam int PW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NR = mcms_pkg::NUM_RUN_REGS;
    localparam logic [17:0] DEAD_LIMIT = 18'(DEAD_TICKS);

    typedef enum logic [3:0] {
        PH_IDLE        = 4'd0,
        PH_SEARCH      = 4'd1,
        PH_OPEN_START  = 4'd2,
        PH_OPEN_RUN    = 4'd3,
        PH_OPEN_STOP   = 4'd4,
        PH_OPEN_DEAD   = 4'd5,
        PH_CLOSE_START = 4'd6,
        PH_CLOSE_RUN   = 4'd7,
        PH_CLOSE_STOP  = 4'd8,
        PH_CLOSE_DEAD  = 4'd9
    } t_phase;

    localparam logic [1:0] MOT_IDLE  = 2'd0;
    localparam logic [1:0] MOT_OPEN  = 2'd1;
    localparam logic [1:0] MOT_CLOSE = 2'd2;

    t_phase      r_phase [NR];
    logic [1:0]  r_motion [NR];
    logic        r_switch [NR];
    logic [7:0]  r_percent [NR];
    logic [17:0] r_count [NR];
    logic [PW-1:0] r_ptr;

    t_phase      n_phase [NR];
    logic [1:0]  n_motion [NR];
    logic        n_switch [NR];
    logic [7:0]  n_percent [NR];
    logic [17:0] n_count [NR];
    logic [PW-1:0] n_ptr;

    logic [PW-1:0] ptr_next;
    logic [1:0]    sidx;
    logic [1:0]    ch;
    logic          acc_en;
    logic          srv_en;
    logic [17:0]   bumped;
    logic [2:0]    cmd;

    assign ch       = i_item.channel;
    assign ptr_next = (r_ptr == PW'(CHANNELS - 1)) ? '0 : r_ptr + PW'(1);
    assign sidx     = 2'(ptr_next);
    assign acc_en   = (32'(ch) < CHANNELS) && i_cfg.enable_mask[ch];
    assign srv_en   = (32'(ptr_next) < CHANNELS) && (32'(ptr_next) < NR) &&
                      i_cfg.enable_mask[sidx];
    assign bumped   = (r_count[sidx] == mcms_pkg::COUNT_MAX) ?
                      r_count[sidx] : r_count[sidx] + 18'd1;

    always_comb begin
        n_phase   = r_phase;
        n_motion  = r_motion;
        n_switch  = r_switch;
        n_percent = r_percent;
        n_count   = r_count;
        n_ptr     = r_ptr;
        o_result  = '0;
        cmd       = mcms_pkg::CMD_NONE;

        unique case (i_item.kind)
            mcms_pkg::KIND_WRITE: begin
                if (!acc_en) begin
                    o_result.error = 1'b1;
                end else begin
                    if (r_switch[ch] != i_item.switch_setting ||
                        r_percent[ch] != i_item.percent) begin
                        n_phase[ch] = PH_SEARCH;
                    end
                    n_switch[ch]  = i_item.switch_setting;
                    n_percent[ch] = i_item.percent;
                end
            end
            mcms_pkg::KIND_READ: begin
                if (!acc_en) begin
                    o_result.error = 1'b1;
                end else begin
                    o_result.read_switch  = r_switch[ch];
                    o_result.read_percent = r_percent[ch];
                end
            end
            mcms_pkg::KIND_TICK: begin
                n_ptr = ptr_next;
                o_result.command_channel = sidx;
                if (!srv_en) begin
                    o_result.error = 1'b1;
                end else begin
                    case (r_phase[sidx])
                        PH_IDLE: ;
                        PH_SEARCH: begin
                            if (r_motion[sidx] == MOT_OPEN) begin
                                n_phase[sidx] = r_switch[sidx] ? PH_OPEN_START
                                                               : PH_OPEN_STOP;
                            end else if (r_motion[sidx] == MOT_CLOSE) begin
                                n_phase[sidx] = r_switch[sidx] ? PH_CLOSE_STOP
                                                               : PH_CLOSE_START;
                            end else begin
                                n_phase[sidx] = r_switch[sidx] ? PH_OPEN_START
                                                               : PH_CLOSE_START;
                            end
                        end
                        PH_OPEN_START: begin
                            n_motion[sidx] = MOT_OPEN;
                            cmd            = mcms_pkg::CMD_OPEN_START;
                            n_phase[sidx]  = PH_OPEN_RUN;
                            n_count[sidx]  = '0;
                        end
                        PH_OPEN_RUN: begin
                            n_count[sidx] = bumped;
                            if (bumped >= i_cfg.run_limit[sidx]) begin
                                n_count[sidx] = '0;
                                n_phase[sidx] = PH_OPEN_DEAD;
                                cmd           = mcms_pkg::CMD_OPEN_STOP;
                            end
                        end
                        PH_OPEN_STOP: begin
                            n_count[sidx] = '0;
                            n_phase[sidx] = PH_OPEN_DEAD;
                            cmd           = mcms_pkg::CMD_OPEN_STOP;
                        end
                        PH_OPEN_DEAD: begin
                            n_count[sidx] = bumped;
                            if (bumped >= DEAD_LIMIT) begin
                                n_count[sidx]  = '0;
                                n_motion[sidx] = MOT_IDLE;
                                n_phase[sidx]  = r_switch[sidx] ? PH_IDLE
                                                                : PH_CLOSE_START;
                            end
                        end
                        PH_CLOSE_START: begin
                            n_motion[sidx] = MOT_CLOSE;
                            cmd            = mcms_pkg::CMD_CLOSE_START;
                            n_phase[sidx]  = PH_CLOSE_RUN;
                            n_count[sidx]  = '0;
                        end
                        PH_CLOSE_RUN: begin
                            n_count[sidx] = bumped;
                            if (bumped >= i_cfg.run_limit[sidx]) begin
                                n_count[sidx] = '0;
                                n_phase[sidx] = PH_CLOSE_DEAD;
                                cmd           = mcms_pkg::CMD_CLOSE_STOP;
                            end
                        end
                        PH_CLOSE_STOP: begin
                            n_count[sidx] = '0;
                            n_phase[sidx] = PH_CLOSE_DEAD;
                            cmd           = mcms_pkg::CMD_CLOSE_STOP;
                        end
                        PH_CLOSE_DEAD: begin
                            n_count[sidx] = bumped;
                            if (bumped >= DEAD_LIMIT) begin
                                n_count[sidx]  = '0;
                                n_motion[sidx] = MOT_IDLE;
                                n_phase[sidx]  = r_switch[sidx] ? PH_OPEN_START
                                                                : PH_IDLE;
                            end
                        end
                        default: begin
                            n_phase[sidx]  = PH_IDLE;
                            n_motion[sidx] = MOT_IDLE;
                        end
                    endcase
                    o_result.motor_command = cmd;
                    if (cmd != mcms_pkg::CMD_NONE) begin
                        o_result.command_percent = r_percent[sidx];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NR; i++) begin
                r_phase[i]   <= PH_IDLE;
                r_motion[i]  <= MOT_IDLE;
                r_switch[i]  <= 1'b0;
                r_percent[i] <= '0;
                r_count[i]   <= '0;
            end
            r_ptr <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_motion  <= n_motion;
            r_switch  <= n_switch;
            r_percent <= n_percent;
            r_count   <= n_count;
            r_ptr     <= n_ptr;
        end
    end

endmodule

// File: sv/multi_channel_motor_run_sequencer.sv
`timescale 1ns / 1ps

// Run sequencer for up to four curtain motors. Each item passes an input register and a
// result register, so the block takes one item every cycle while the output does not stall;
// a result is registered when its item leaves the input register, and all channel state is
// updated in the single step between the two registers. Write items set a channel's direction
// and percent, read items return them, and tick items step the next channel in round-robin
// order through start, run, stop and dead time. Run times are converted to tick limits when
// the configuration register is written, so configuration takes effect on the next item.
module multi_channel_motor_run_sequencer #(
    parameter int CHANNELS         = 4,
    parameter int DEAD_TICKS       = 200,
    parameter int TICKS_PER_SECOND = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  mcms_pkg::t_in_item    i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output mcms_pkg::t_out_item   o_out_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic                 r_in_valid;
    mcms_pkg::t_in_item   r_in_item;
    logic                 r_out_valid;
    mcms_pkg::t_out_item  r_out_item;

    mcms_pkg::t_cfg       cfg;
    mcms_pkg::t_out_item  step_result;
    logic                 out_free;
    logic                 advance;
    logic                 in_take;

    mcms_cfg #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mcms_core #(
        .CHANNELS   (CHANNELS),
        .DEAD_TICKS (DEAD_TICKS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= in_take || (r_in_valid && !advance);
            r_out_valid <= advance || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_error_no_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.error |-> o_out_item.motor_command == mcms_pkg::CMD_NONE)
        else $error("Error result carries a motor command.");

    a_command_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.motor_command != mcms_pkg::CMD_NONE |->
            !o_out_item.read_switch && o_out_item.read_percent == 8'd0)
        else $error("Motor command result carries read data.");

    a_held_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_item))
        else $error("Held input item was lost or changed.");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out_item))
        else $error("Stalled result was overwritten.");

endmodule
